// ===== design/object_pool_active_free_lists_top_assert.svh =====
// Assertion macros used by the object pool sequencer (opafl_ctrl).
`ifndef OBJECT_POOL_ACTIVE_FREE_LISTS_TOP_ASSERT_SVH
`define OBJECT_POOL_ACTIVE_FREE_LISTS_TOP_ASSERT_SVH

`ifndef SYNTH
`define OPAFL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("object pool assertion failed");
`define OPAFL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("object pool assertion failed");
`else
`define OPAFL_ASSERT_IMPL(lbl, ante, cons)
`define OPAFL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/opafl_pkg.sv =====
// Package with operation codes, status codes and memory control types of the object pool.
`timescale 1ns / 1ps

package opafl_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;

    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic use_we;
    } t_mem_we;

endpackage

// ===== design/opafl_link_mem.sv =====
// Link and in-use memories of the object pool, one write and one registered read each.
`timescale 1ns / 1ps

module opafl_link_mem #(
    parameter int DEPTH = 64,
    parameter int IW    = 6,
    parameter int LW    = 7
) (
    input  logic                i_clk,
    input  opafl_pkg::t_mem_we  i_we,
    input  logic [IW-1:0]       i_next_addr,
    input  logic [LW-1:0]       i_next_data,
    input  logic [IW-1:0]       i_prev_addr,
    input  logic [LW-1:0]       i_prev_data,
    input  logic [IW-1:0]       i_use_addr,
    input  logic                i_use_data,
    input  logic [IW-1:0]       i_rd_addr,
    output logic [LW-1:0]       o_next_rd,
    output logic [LW-1:0]       o_prev_rd,
    output logic                o_use_rd
);

    logic [LW-1:0] next_mem [DEPTH];
    logic [LW-1:0] prev_mem [DEPTH];
    logic          use_mem  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we.next_we) begin
            next_mem[i_next_addr] <= i_next_data;
        end
        o_next_rd <= next_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.prev_we) begin
            prev_mem[i_prev_addr] <= i_prev_data;
        end
        o_prev_rd <= prev_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.use_we) begin
            use_mem[i_use_addr] <= i_use_data;
        end
        o_use_rd <= use_mem[i_rd_addr];
    end

endmodule

// ===== design/opafl_ctrl.sv =====
// Sequencer of the object pool: list heads, shared null compare and memory write steps.
`timescale 1ns / 1ps
`include "object_pool_active_free_lists_top_assert.svh"

module opafl_ctrl #(
    parameter int POOL_SIZE = 64,
    parameter int IW        = 6,
    parameter int LW        = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [opafl_pkg::KIND_W-1:0]      i_kind,
    input  logic [5:0]                        i_slot_index,
    input  logic                              i_out_free,
    output logic                              o_done,
    output logic [opafl_pkg::STATUS_W-1:0]    o_status,
    output logic [IW-1:0]                     o_granted,
    output logic [LW-1:0]                     o_act_head,
    output logic [LW-1:0]                     o_free_head,
    output opafl_pkg::t_mem_we                o_we,
    output logic [IW-1:0]                     o_next_addr,
    output logic [LW-1:0]                     o_next_data,
    output logic [IW-1:0]                     o_prev_addr,
    output logic [LW-1:0]                     o_prev_data,
    output logic [IW-1:0]                     o_use_addr,
    output logic                              o_use_data,
    output logic [IW-1:0]                     o_rd_addr,
    input  logic [LW-1:0]                     i_next_rd,
    input  logic [LW-1:0]                     i_prev_rd,
    input  logic                              i_use_rd
);

    localparam logic [LW-1:0] NIL  = LW'(POOL_SIZE);
    localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_W0    = 3'd2;
    localparam logic [2:0] S_W1    = 3'd3;
    localparam logic [2:0] S_W2    = 3'd4;
    localparam logic [2:0] S_W3    = 3'd5;
    localparam logic [2:0] S_SWEEP = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]                           r_state;
    logic [opafl_pkg::KIND_W-1:0]         r_kind;
    logic [opafl_pkg::STATUS_W-1:0]       r_status;
    logic [IW-1:0]                        r_e;
    logic [LW-1:0]                        r_n;
    logic [LW-1:0]                        r_p;
    logic                                 r_p_live;
    logic [IW-1:0]                        r_cnt;
    logic                                 r_boot;
    logic [LW-1:0]                        r_act_head;
    logic [LW-1:0]                        r_free_head;

    logic [LW+5:0] s_idx_ext;
    logic          s_idx_ok;
    logic          s_is_alloc;
    logic [LW-1:0] s_oh;
    logic [LW-1:0] s_link;
    logic          s_live;

    assign s_idx_ext  = {{LW{1'b0}}, i_slot_index};
    assign s_idx_ok   = s_idx_ext < (LW + 6)'(POOL_SIZE);
    assign s_is_alloc = (r_kind == opafl_pkg::KIND_ALLOC);
    assign s_oh       = s_is_alloc ? r_act_head : r_free_head;

    always_comb begin
        unique case (r_state)
            S_IDLE:  s_link = r_free_head;
            S_W0:    s_link = r_p;
            S_W1:    s_link = r_n;
            S_W2:    s_link = s_oh;
            default: s_link = NIL;
        endcase
    end

    assign s_live = s_link < NIL;

    assign o_rd_addr = (i_kind == opafl_pkg::KIND_ALLOC) ? r_free_head[IW-1:0]
                                                         : s_idx_ext[IW-1:0];

    always_comb begin
        o_we        = '0;
        o_next_addr = r_e;
        o_next_data = r_n;
        o_prev_addr = r_e;
        o_prev_data = NIL;
        o_use_addr  = r_e;
        o_use_data  = s_is_alloc;
        unique case (r_state)
            S_W0: begin
                o_we.next_we = s_live;
                o_next_addr  = r_p[IW-1:0];
                o_next_data  = r_n;
            end
            S_W1: begin
                o_we.prev_we = s_live;
                o_prev_addr  = r_n[IW-1:0];
                o_prev_data  = s_is_alloc ? NIL : r_p;
            end
            S_W2: begin
                o_we.prev_we = s_live;
                o_prev_addr  = s_oh[IW-1:0];
                o_prev_data  = LW'(r_e);
                o_we.next_we = 1'b1;
                o_next_data  = s_oh;
                o_we.use_we  = 1'b1;
            end
            S_W3: begin
                o_we.prev_we = 1'b1;
            end
            S_SWEEP: begin
                o_we        = '1;
                o_next_addr = r_cnt;
                o_next_data = (r_cnt == LAST) ? NIL : LW'(r_cnt) + LW'(1);
                o_prev_addr = r_cnt;
                o_prev_data = (r_cnt == '0) ? NIL : LW'(r_cnt) - LW'(1);
                o_use_addr  = r_cnt;
                o_use_data  = 1'b0;
            end
            default: begin
                o_we = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_cnt       <= '0;
            r_boot      <= 1'b1;
            r_act_head  <= NIL;
            r_free_head <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind <= i_kind;
                        unique case (i_kind)
                            opafl_pkg::KIND_ALLOC: begin
                                r_e <= r_free_head[IW-1:0];
                                if (s_live) begin
                                    r_status <= opafl_pkg::ST_DONE;
                                    r_state  <= S_READ;
                                end else begin
                                    r_status <= opafl_pkg::ST_EXHAUSTED;
                                    r_state  <= S_FIN;
                                end
                            end
                            opafl_pkg::KIND_RELEASE: begin
                                r_e <= s_idx_ext[IW-1:0];
                                if (s_idx_ok) begin
                                    r_status <= opafl_pkg::ST_DONE;
                                    r_state  <= S_READ;
                                end else begin
                                    r_status <= opafl_pkg::ST_NOT_ACTIVE;
                                    r_state  <= S_FIN;
                                end
                            end
                            opafl_pkg::KIND_RESET: begin
                                r_status <= opafl_pkg::ST_DONE;
                                r_cnt    <= '0;
                                r_boot   <= 1'b0;
                                r_state  <= S_SWEEP;
                            end
                            default: begin
                                r_status <= opafl_pkg::ST_DONE;
                                r_state  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_n <= i_next_rd;
                    r_p <= i_prev_rd;
                    if (s_is_alloc) begin
                        r_state <= S_W1;
                    end else if (i_use_rd) begin
                        r_state <= S_W0;
                    end else begin
                        r_status <= opafl_pkg::ST_NOT_ACTIVE;
                        r_state  <= S_FIN;
                    end
                end
                S_W0: begin
                    r_p_live <= s_live;
                    r_state  <= S_W1;
                end
                S_W1: begin
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_state <= S_W3;
                end
                S_W3: begin
                    if (s_is_alloc) begin
                        r_free_head <= r_n;
                        r_act_head  <= LW'(r_e);
                    end else begin
                        if (!r_p_live) begin
                            r_act_head <= r_n;
                        end
                        r_free_head <= LW'(r_e);
                    end
                    r_state <= S_FIN;
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + IW'(1);
                    if (r_cnt == LAST) begin
                        r_act_head  <= NIL;
                        r_free_head <= '0;
                        r_state     <= r_boot ? S_IDLE : S_FIN;
                    end
                end
                S_FIN: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_done      = (r_state == S_FIN) && i_out_free;
    assign o_status    = r_status;
    assign o_granted   = (s_is_alloc && r_status == opafl_pkg::ST_DONE) ? r_e : '0;
    assign o_act_head  = r_act_head;
    assign o_free_head = r_free_head;

    `OPAFL_ASSERT_IMPL(a_heads_distinct, r_act_head != NIL, r_act_head != r_free_head)
    `OPAFL_ASSERT_IMPL(a_exhaust_null, o_done && o_status == opafl_pkg::ST_EXHAUSTED, r_free_head == NIL)
    `OPAFL_ASSERT_NEXT(a_alloc_head, r_state == S_W3 && s_is_alloc, r_act_head == LW'(r_e))

endmodule

// ===== design/object_pool_active_free_lists_top.sv =====
// Top level of the object pool with active and free doubly linked lists.
//
//   channel   direction   handshake            payload
//   request   in          i_valid / o_ready    i_kind, i_slot_index
//   result    out         o_valid / i_ready    o_status, o_granted_index,
//                                              o_active_list_head, o_free_list_head
//
// Allocate runs the read step and write steps W1 to W3, release the read step
// and W0 to W3, with one write per link memory per step; an exhausted allocate
// or an unused code goes straight to the result, an inactive release after READ.
// Pool reset sweeps the link memories, one entry a cycle.
// After i_rst_n the same sweep runs with o_ready low.
// A stalled result holds in the output register; the next request is still taken.
`timescale 1ns / 1ps

module object_pool_active_free_lists_top #(
    parameter int POOL_SIZE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [5:0] i_slot_index,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [5:0] o_granted_index,
    output logic [6:0] o_active_list_head,
    output logic [6:0] o_free_list_head
);

    localparam int IW = $clog2(POOL_SIZE);
    localparam int LW = $clog2(POOL_SIZE + 1);

    opafl_pkg::t_mem_we                   s_we;
    logic [IW-1:0]                        s_next_addr;
    logic [LW-1:0]                        s_next_data;
    logic [IW-1:0]                        s_prev_addr;
    logic [LW-1:0]                        s_prev_data;
    logic [IW-1:0]                        s_use_addr;
    logic                                 s_use_data;
    logic [IW-1:0]                        s_rd_addr;
    logic [LW-1:0]                        s_next_rd;
    logic [LW-1:0]                        s_prev_rd;
    logic                                 s_use_rd;
    logic                                 s_out_free;
    logic                                 s_done;
    logic [opafl_pkg::STATUS_W-1:0]       s_status;
    logic [IW-1:0]                        s_granted;
    logic [LW-1:0]                        s_act_head;
    logic [LW-1:0]                        s_free_head;
    logic [IW+5:0]                        s_granted_ext;
    logic [LW+6:0]                        s_ah_ext;
    logic [LW+6:0]                        s_fh_ext;

    logic                                 r_out_valid;
    logic [1:0]                           r_status;
    logic [5:0]                           r_granted;
    logic [6:0]                           r_act_head;
    logic [6:0]                           r_free_head;

    opafl_link_mem #(
        .DEPTH (POOL_SIZE),
        .IW    (IW),
        .LW    (LW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_we        (s_we),
        .i_next_addr (s_next_addr),
        .i_next_data (s_next_data),
        .i_prev_addr (s_prev_addr),
        .i_prev_data (s_prev_data),
        .i_use_addr  (s_use_addr),
        .i_use_data  (s_use_data),
        .i_rd_addr   (s_rd_addr),
        .o_next_rd   (s_next_rd),
        .o_prev_rd   (s_prev_rd),
        .o_use_rd    (s_use_rd)
    );

    opafl_ctrl #(
        .POOL_SIZE (POOL_SIZE),
        .IW        (IW),
        .LW        (LW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_slot_index  (i_slot_index),
        .i_out_free    (s_out_free),
        .o_done        (s_done),
        .o_status      (s_status),
        .o_granted     (s_granted),
        .o_act_head    (s_act_head),
        .o_free_head   (s_free_head),
        .o_we          (s_we),
        .o_next_addr   (s_next_addr),
        .o_next_data   (s_next_data),
        .o_prev_addr   (s_prev_addr),
        .o_prev_data   (s_prev_data),
        .o_use_addr    (s_use_addr),
        .o_use_data    (s_use_data),
        .o_rd_addr     (s_rd_addr),
        .i_next_rd     (s_next_rd),
        .i_prev_rd     (s_prev_rd),
        .i_use_rd      (s_use_rd)
    );

    assign s_out_free    = !r_out_valid || i_ready;
    assign s_granted_ext = {6'b0, s_granted};
    assign s_ah_ext      = {7'b0, s_act_head};
    assign s_fh_ext      = {7'b0, s_free_head};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_done) begin
            r_status    <= s_status;
            r_granted   <= s_granted_ext[5:0];
            r_act_head  <= s_ah_ext[6:0];
            r_free_head <= s_fh_ext[6:0];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_status;
    assign o_granted_index    = r_granted;
    assign o_active_list_head = r_act_head;
    assign o_free_list_head   = r_free_head;

endmodule
